/* hdl/srs_pkg.sv */
package srs_pkg;

  localparam int CAP_W    = 16;
  localparam int PERIOD_W = 17;
  localparam int POS_W    = 14;
  localparam int DIST_W   = 13;
  localparam int DEG_W    = 8;
  localparam int AUS_W    = 15;
  localparam int ADEG_W   = 12;
  localparam int CFG_W    = 17;
  localparam int IDX_W    = 3;

  localparam logic [POS_W-1:0]    RIGHT_LIMIT_RST = POS_W'(800);
  localparam logic [POS_W-1:0]    LEFT_LIMIT_RST  = POS_W'(2200);
  localparam logic [POS_W-1:0]    NEUTRAL_RST     = POS_W'(1500);
  localparam logic [DIST_W-1:0]   DANGER_RST      = DIST_W'(200);
  localparam logic [PERIOD_W-1:0] PERIOD_RST      = PERIOD_W'(32201);
  localparam logic [PERIOD_W-1:0] PERIOD_FULL     = PERIOD_W'(65536);

  localparam logic [POS_W-1:0]  STEP_US  = POS_W'(100);
  localparam logic [POS_W-1:0]  POS_MAX  = POS_W'(16383);
  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(8191);
  localparam logic [DEG_W-1:0]  MAX_DEG  = DEG_W'(165);

  // floor(x / 29) = (x * DIV29_MUL) >> DIV29_SHIFT for x below 2**20
  localparam int DIV29_SHIFT = 24;
  localparam logic [19:0] DIV29_MUL = 20'd578525;
  // floor(u / 17) = (u * DIV17_MUL) >> DIV17_SHIFT for u below 2**16
  localparam int DIV17_SHIFT = 20;
  localparam logic [16:0] DIV17_MUL = 17'd61681;

  typedef enum logic [1:0] {
    FUNC_ECHO    = 2'd0,
    FUNC_DANGER  = 2'd1,
    FUNC_TURN    = 2'd2,
    FUNC_NEUTRAL = 2'd3
  } func_t;

  typedef enum logic [IDX_W-1:0] {
    REG_RIGHT_LIMIT = 3'd0,
    REG_LEFT_LIMIT  = 3'd1,
    REG_NEUTRAL     = 3'd2,
    REG_DANGER      = 3'd3,
    REG_MEASURE_EN  = 3'd4,
    REG_PERIOD      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0]    right_limit;
    logic [POS_W-1:0]    left_limit;
    logic [POS_W-1:0]    center_pulse;
    logic [DIST_W-1:0]   danger_distance;
    logic                measure_enable;
    logic [PERIOD_W-1:0] counter_period;
  } cfg_t;

  typedef struct packed {
    func_t            func;
    logic [DEG_W-1:0] deg;
    logic             fall;
  } item_t;

  // one restoring step of a remainder: shift in one dividend bit, subtract if it fits
  function automatic logic [PERIOD_W-1:0] mod_step(input logic [PERIOD_W-1:0] rem,
                                                   input logic dbit,
                                                   input logic [PERIOD_W-1:0] q);
    logic [PERIOD_W:0] t;
    logic [PERIOD_W:0] qx;
    t  = {rem, dbit};
    qx = {1'b0, q};
    if (t >= qx) begin
      t = t - qx;
    end
    return t[PERIOD_W-1:0];
  endfunction

endpackage

/* hdl/srs_cfg.sv */
module srs_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [srs_pkg::IDX_W-1:0]    cfg_index,
  input  logic [srs_pkg::CFG_W-1:0]    cfg_data,
  output srs_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.right_limit      <= srs_pkg::RIGHT_LIMIT_RST;
      cfg.left_limit       <= srs_pkg::LEFT_LIMIT_RST;
      cfg.center_pulse     <= srs_pkg::NEUTRAL_RST;
      cfg.danger_distance  <= srs_pkg::DANGER_RST;
      cfg.measure_enable   <= 1'b1;
      cfg.counter_period   <= srs_pkg::PERIOD_RST;
    end else if (cfg_write) begin
      unique case (srs_pkg::reg_idx_t'(cfg_index))
        srs_pkg::REG_RIGHT_LIMIT: cfg.right_limit <= cfg_data[srs_pkg::POS_W-1:0];
        srs_pkg::REG_LEFT_LIMIT:  cfg.left_limit <= cfg_data[srs_pkg::POS_W-1:0];
        srs_pkg::REG_NEUTRAL:     cfg.center_pulse <= cfg_data[srs_pkg::POS_W-1:0];
        srs_pkg::REG_DANGER:      cfg.danger_distance <= cfg_data[srs_pkg::DIST_W-1:0];
        srs_pkg::REG_MEASURE_EN:  cfg.measure_enable <= cfg_data[0];
        srs_pkg::REG_PERIOD:      cfg.counter_period <= cfg_data[srs_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hdl/srs_mod_pipe.sv */
module srs_mod_pipe (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            take,
  input  logic [1:0]                      func,
  input  logic [srs_pkg::CAP_W-1:0]       cap,
  input  logic [srs_pkg::DEG_W-1:0]       deg,
  input  srs_pkg::cfg_t                   cfg,
  output logic                            o_valid,
  output srs_pkg::item_t                  o_item,
  output logic [srs_pkg::CAP_W-1:0]       o_cap_mod,
  output logic [srs_pkg::CAP_W-1:0]       o_rise_mod,
  output logic [srs_pkg::PERIOD_W-1:0]    o_q
);

  localparam int NB = srs_pkg::CAP_W;

  logic                          vld   [0:NB];
  srs_pkg::item_t                itm   [0:NB];
  logic [NB-1:0]                 cbits [0:NB];
  logic [NB-1:0]                 rbits [0:NB];
  logic [srs_pkg::PERIOD_W-1:0]  rc    [0:NB];
  logic [srs_pkg::PERIOD_W-1:0]  rr    [0:NB];

  logic                  edge_phase;
  logic [NB-1:0]         rising_capture;
  logic                  is_echo;
  logic [srs_pkg::PERIOD_W-1:0] q;

  // period of zero means the full 16-bit counter range
  assign q = (cfg.counter_period == '0) ? srs_pkg::PERIOD_FULL : cfg.counter_period;
  assign is_echo = (srs_pkg::func_t'(func) == srs_pkg::FUNC_ECHO) && cfg.measure_enable;

  // edge pairing is decided at entry, it depends on nothing computed downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0]     <= 1'b0;
      edge_phase <= 1'b0;
    end else if (adv) begin
      vld[0] <= take;
      if (take && is_echo) begin
        edge_phase <= ~edge_phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take && is_echo && !edge_phase) begin
      rising_capture <= cap;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      itm[0].func <= srs_pkg::func_t'(func);
      itm[0].deg  <= deg;
      itm[0].fall <= is_echo && edge_phase;
      cbits[0]    <= cap;
      rbits[0]    <= rising_capture;
      rc[0]       <= '0;
      rr[0]       <= '0;
    end
  end

  // one dividend bit per stage for both captures
  for (genvar k = 0; k < NB; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        itm[k+1]   <= itm[k];
        cbits[k+1] <= {cbits[k][NB-2:0], 1'b0};
        rbits[k+1] <= {rbits[k][NB-2:0], 1'b0};
        rc[k+1]    <= srs_pkg::mod_step(rc[k], cbits[k][NB-1], q);
        rr[k+1]    <= srs_pkg::mod_step(rr[k], rbits[k][NB-1], q);
      end
    end
  end

  assign o_valid    = vld[NB];
  assign o_item     = itm[NB];
  assign o_cap_mod  = rc[NB][NB-1:0];
  assign o_rise_mod = rr[NB][NB-1:0];
  assign o_q        = q;

endmodule

/* hdl/srs_range.sv */
module srs_range (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            i_valid,
  input  srs_pkg::item_t                  i_item,
  input  logic [srs_pkg::CAP_W-1:0]       i_cap_mod,
  input  logic [srs_pkg::CAP_W-1:0]       i_rise_mod,
  input  logic [srs_pkg::PERIOD_W-1:0]    i_q,
  output logic                            o_valid,
  output srs_pkg::item_t                  o_item,
  output logic [srs_pkg::DIST_W-1:0]      o_mm
);

  localparam int PW = srs_pkg::PERIOD_W;

  logic                 a_valid;
  srs_pkg::item_t       a_item;
  logic [PW-1:0]        a_diff;
  logic [PW-1:0]        diff_next;
  logic [PW+2:0]        x5;
  logic [PW+22:0]       prod;
  logic [15:0]          quo;
  logic [srs_pkg::DIST_W-1:0] mm_next;

  // difference modulo the period, both operands already below it
  always_comb begin
    if (i_cap_mod >= i_rise_mod) begin
      diff_next = PW'(i_cap_mod) - PW'(i_rise_mod);
    end else begin
      diff_next = i_q - PW'(i_rise_mod) + PW'(i_cap_mod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= i_valid;
      o_valid <= a_valid;
    end
  end

  // mm = d * 10 / 58 = d * 5 / 29
  always_comb begin
    x5   = ({3'b0, a_diff} << 2) + {3'b0, a_diff};
    prod = x5 * srs_pkg::DIV29_MUL;
    quo  = prod[srs_pkg::DIV29_SHIFT +: 16];
    if (quo > 16'(srs_pkg::DIST_MAX)) begin
      mm_next = srs_pkg::DIST_MAX;
    end else begin
      mm_next = quo[srs_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item <= i_item;
      a_diff <= diff_next;
      o_item <= a_item;
      o_mm   <= mm_next;
    end
  end

endmodule

/* hdl/srs_state.sv */
module srs_state (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             i_valid,
  input  srs_pkg::item_t                   i_item,
  input  logic [srs_pkg::DIST_W-1:0]       i_mm,
  input  srs_pkg::cfg_t                    cfg,
  output logic                             out_valid,
  output logic [srs_pkg::DIST_W-1:0]       distance_mm,
  output logic                             distance_new,
  output logic [srs_pkg::POS_W-1:0]        servo_pulse,
  output logic signed [srs_pkg::AUS_W-1:0] angle_us,
  output logic signed [srs_pkg::ADEG_W-1:0] angle_deg,
  output logic                             obstacle_near,
  output logic                             sweep_active
);

  localparam int PSW = srs_pkg::POS_W;

  logic [srs_pkg::DIST_W-1:0] distance_store, distance_store_next;
  logic [PSW-1:0]             servo_position, servo_position_next;
  logic                       sweep_toward_left, sweep_toward_left_next;
  logic                       sweep_on, sweep_on_next;
  logic                       detected_flag, detected_flag_next;
  logic                       fresh_next;
  logic [PSW:0]               pos_up;
  logic [12:0]                deg17;
  logic [PSW:0]               turn_sum;
  logic [PSW+1:0]             aus_wide;

  logic                       c_valid;
  logic                       c_fresh;
  logic [srs_pkg::AUS_W-1:0]  c_aus;
  logic [srs_pkg::DIST_W-1:0] c_dist;
  logic [PSW-1:0]             c_pos;
  logic                       c_det;
  logic                       c_sweep;

  logic [15:0]                aus5;
  logic [16:0]                twice;
  logic [16:0]                mag;
  logic [32:0]                dprod;
  logic [12:0]                dquo;

  always_comb begin
    distance_store_next    = distance_store;
    servo_position_next    = servo_position;
    sweep_toward_left_next = sweep_toward_left;
    sweep_on_next          = sweep_on;
    detected_flag_next     = detected_flag;
    fresh_next             = 1'b0;
    pos_up   = {1'b0, servo_position} + {1'b0, srs_pkg::STEP_US};
    deg17    = ({5'b0, i_item.deg} << 4) + {5'b0, i_item.deg};
    turn_sum = {1'b0, cfg.right_limit} + {3'b0, deg17[12:1]};
    unique case (i_item.func)
      srs_pkg::FUNC_ECHO: begin
        if (i_item.fall) begin
          distance_store_next = i_mm;
          fresh_next          = 1'b1;
          if (sweep_on) begin
            // right limit wins when both limits match
            if (servo_position == cfg.left_limit) sweep_toward_left_next = 1'b0;
            if (servo_position == cfg.right_limit) sweep_toward_left_next = 1'b1;
            if (sweep_toward_left_next) begin
              if (servo_position < cfg.left_limit) begin
                servo_position_next = pos_up[PSW] ? srs_pkg::POS_MAX : pos_up[PSW-1:0];
              end
            end else if (servo_position > cfg.right_limit) begin
              servo_position_next = (servo_position >= srs_pkg::STEP_US) ?
                                    servo_position - srs_pkg::STEP_US : '0;
            end
          end
        end
      end
      srs_pkg::FUNC_DANGER: begin
        detected_flag_next = (distance_store <= cfg.danger_distance);
        sweep_on_next      = !(distance_store <= cfg.danger_distance);
      end
      srs_pkg::FUNC_TURN: begin
        if (i_item.deg <= srs_pkg::MAX_DEG) begin
          servo_position_next = turn_sum[PSW] ? srs_pkg::POS_MAX : turn_sum[PSW-1:0];
        end
      end
      srs_pkg::FUNC_NEUTRAL: begin
        servo_position_next = cfg.center_pulse;
      end
      default: ;
    endcase
    aus_wide = {2'b0, servo_position_next} - {2'b0, cfg.right_limit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_store    <= '0;
      servo_position    <= srs_pkg::NEUTRAL_RST;
      sweep_toward_left <= 1'b0;
      sweep_on          <= 1'b0;
      detected_flag     <= 1'b0;
      c_valid           <= 1'b0;
      out_valid         <= 1'b0;
    end else if (adv) begin
      c_valid   <= i_valid;
      out_valid <= c_valid;
      if (i_valid) begin
        distance_store    <= distance_store_next;
        servo_position    <= servo_position_next;
        sweep_toward_left <= sweep_toward_left_next;
        sweep_on          <= sweep_on_next;
        detected_flag     <= detected_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_fresh <= fresh_next;
      c_aus   <= aus_wide[srs_pkg::AUS_W-1:0];
      c_dist  <= distance_store_next;
      c_pos   <= servo_position_next;
      c_det   <= detected_flag_next;
      c_sweep <= sweep_on_next;
    end
  end

  // angle_deg = trunc(2 * (aus + 5) / 17), toward zero
  always_comb begin
    aus5  = {c_aus[srs_pkg::AUS_W-1], c_aus} + 16'd5;
    twice = {aus5, 1'b0};
    mag   = twice[16] ? (~twice + 17'd1) : twice;
    dprod = mag[15:0] * srs_pkg::DIV17_MUL;
    dquo  = dprod[srs_pkg::DIV17_SHIFT +: 13];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      distance_mm     <= c_dist;
      distance_new    <= c_fresh;
      servo_pulse     <= c_pos;
      angle_us        <= $signed(c_aus);
      angle_deg       <= twice[16] ? $signed(~dquo[srs_pkg::ADEG_W-1:0] + 12'd1)
                                   : $signed(dquo[srs_pkg::ADEG_W-1:0]);
      obstacle_near   <= c_det;
      sweep_active    <= c_sweep;
    end
  end

endmodule

/* hdl/sonar_ranging_servo_sweep.sv */
// sonar ranging with a sweeping servo
// input channel (in_valid/in_ready) carries one command per transfer: func selects
// echo edge capture, danger check, turn to target_degrees, or return to neutral.
// echo edges pair up as rising then falling; a falling edge yields a new distance
// in mm and, with sweep on, moves the servo one 100 us step.
// output channel (out_valid/out_ready) returns exactly one result per command with
// the distance, servo pulse, angle and sweep status after that command.
// one command is taken every cycle unless the output holds the pipe. the depth is
// set by an entry stage and the capture remainder, one bit per stage over the 16
// bits of the capture, then difference, distance scaling, state update and angle
// stages.
// when out_ready is low with a result waiting the whole pipe holds and in_ready
// drops in the same cycle; nothing is lost or repeated.
// reset clears the pipe, loads the register defaults and puts the servo at 1500 us
// with sweep off. registers are written through cfg_write/cfg_index/cfg_data and
// should only change while no command is in flight.
module sonar_ranging_servo_sweep (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        func,
  input  logic [srs_pkg::CAP_W-1:0]         capture_value,
  input  logic [srs_pkg::DEG_W-1:0]         target_degrees,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [srs_pkg::DIST_W-1:0]        distance_mm,
  output logic                              distance_new,
  output logic [srs_pkg::POS_W-1:0]         servo_pulse,
  output logic signed [srs_pkg::AUS_W-1:0]  angle_us,
  output logic signed [srs_pkg::ADEG_W-1:0] angle_deg,
  output logic                              obstacle_near,
  output logic                              sweep_active,
  input  logic                              cfg_write,
  input  logic [srs_pkg::IDX_W-1:0]         cfg_index,
  input  logic [srs_pkg::CFG_W-1:0]         cfg_data
);

  srs_pkg::cfg_t                 cfg;
  logic                          adv;
  logic                          m_valid;
  srs_pkg::item_t                m_item;
  logic [srs_pkg::CAP_W-1:0]     m_cap_mod;
  logic [srs_pkg::CAP_W-1:0]     m_rise_mod;
  logic [srs_pkg::PERIOD_W-1:0]  m_q;
  logic                          r_valid;
  srs_pkg::item_t                r_item;
  logic [srs_pkg::DIST_W-1:0]    r_mm;

  // whole pipe moves unless a result is held at the output
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  srs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srs_mod_pipe u_mod (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .take       (in_valid && adv),
    .func       (func),
    .cap        (capture_value),
    .deg        (target_degrees),
    .cfg        (cfg),
    .o_valid    (m_valid),
    .o_item     (m_item),
    .o_cap_mod  (m_cap_mod),
    .o_rise_mod (m_rise_mod),
    .o_q        (m_q)
  );

  srs_range u_range (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .i_valid    (m_valid),
    .i_item     (m_item),
    .i_cap_mod  (m_cap_mod),
    .i_rise_mod (m_rise_mod),
    .i_q        (m_q),
    .o_valid    (r_valid),
    .o_item     (r_item),
    .o_mm       (r_mm)
  );

  srs_state u_state (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .i_valid         (r_valid),
    .i_item          (r_item),
    .i_mm            (r_mm),
    .cfg             (cfg),
    .out_valid       (out_valid),
    .distance_mm     (distance_mm),
    .distance_new    (distance_new),
    .servo_pulse     (servo_pulse),
    .angle_us        (angle_us),
    .angle_deg       (angle_deg),
    .obstacle_near   (obstacle_near),
    .sweep_active    (sweep_active)
  );

endmodule
